// ===== design/lif_pkg.sv =====
// lif_pkg: types, constants and helpers for the lan ipv4 ingress filter
// no dependencies; imported by lif_regs, lan_ipv4_ingress_filter and the test bench
package lif_pkg;

  // protocol numbers
  localparam logic [7:0] PROTO_ICMP = 8'd1;
  localparam logic [7:0] PROTO_TCP  = 8'd6;
  localparam logic [7:0] PROTO_UDP  = 8'd17;

  localparam logic [3:0] IP_VER4 = 4'd4;

  // octet limits used by the address tests
  localparam logic [7:0]  OCT_MCAST    = 8'd224;
  localparam logic [7:0]  OCT_PRIV     = 8'd192;
  localparam logic [7:0]  OCT_MIN_HOST = 8'd3;
  localparam logic [15:0] MID_BCAST    = 16'hffff;

  // path codes
  localparam logic [1:0] PATH_NONE = 2'd0;
  localparam logic [1:0] PATH_HOST = 2'd1;
  localparam logic [1:0] PATH_OWN  = 2'd2;

  // register file
  localparam int unsigned ADDR_W = 5;
  localparam int unsigned DATA_W = 32;

  typedef enum logic [2:0] {
    REG_LAN_ADDR    = 3'd0,
    REG_WLAN_ADDR   = 3'd1,
    REG_LOOP_ADDR   = 3'd2,
    REG_LAN_MASK    = 3'd3,
    REG_WLAN_MASK   = 3'd4,
    REG_LISTEN_PORT = 3'd5,
    REG_SERIAL_MODE = 3'd6,
    REG_UNUSED      = 3'd7
  } reg_idx_t;

  localparam logic [31:0] LOOP_ADDR_RST   = 32'h0100_007f;
  localparam logic [15:0] LISTEN_PORT_RST = 16'd20150;

  typedef struct packed {
    logic [31:0] lan_addr;
    logic [31:0] wlan_addr;
    logic [31:0] loop_addr;
    logic [31:0] lan_mask;
    logic [31:0] wlan_mask;
    logic [15:0] listen_port;
    logic        serial_mode;
  } cfg_t;

  typedef struct packed {
    logic [3:0]  ip_version;
    logic [7:0]  protocol;
    logic [31:0] src_addr;
    logic [31:0] dst_addr;
    logic [15:0] dest_port;
  } in_word_t;

  typedef struct packed {
    logic       accept;
    logic [1:0] path;
  } out_word_t;

  // compare flags carried from the first to the second stage
  typedef struct packed {
    logic ver_ok;
    logic serial;
    logic src_in_lan;
    logic src_last_ok;
    logic src_eq_lan;
    logic src_eq_wlan;
    logic src_eq_loop;
    logic dst_eq_loop;
    logic dst_in_lan;
    logic dst_masked_bad;
    logic dst_first_priv;
    logic dst_mid_ok;
    logic dst_last_ok;
    logic is_icmp;
    logic is_tcp;
    logic is_udp;
    logic port_blocked;
    logic port_is_listen;
  } flags_t;

  function automatic logic port_blocked(input logic [15:0] p);
    logic hit;
    case (p)
      16'd53, 16'd80, 16'd137, 16'd138, 16'd433, 16'd445,
      16'd5353, 16'd5355, 16'd8000, 16'd8080,
      16'd11711, 16'd3478, 16'd15712: hit = 1'b1;
      default: hit = 1'b0;
    endcase
    return hit;
  endfunction

endpackage

// ===== design/lif_regs.sv =====
// lif_regs: apb-style configuration registers of the ingress filter
// depends on lif_pkg
module lif_regs (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [lif_pkg::ADDR_W-1:0]  paddr,
  input  logic [lif_pkg::DATA_W-1:0]  pwdata,
  output logic [lif_pkg::DATA_W-1:0]  prdata,
  output logic                        pready,
  output lif_pkg::cfg_t               cfg
);
  import lif_pkg::*;

  cfg_t     cfg_r;
  cfg_t     cfg_nxt;
  reg_idx_t idx;
  logic     wr_en;

  assign idx    = reg_idx_t'(paddr[ADDR_W-1:2]);
  assign wr_en  = psel & penable & pwrite;
  assign pready = 1'b1;
  assign cfg    = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (idx)
        REG_LAN_ADDR:    cfg_nxt.lan_addr    = pwdata;
        REG_WLAN_ADDR:   cfg_nxt.wlan_addr   = pwdata;
        REG_LOOP_ADDR:   cfg_nxt.loop_addr   = pwdata;
        REG_LAN_MASK:    cfg_nxt.lan_mask    = pwdata;
        REG_WLAN_MASK:   cfg_nxt.wlan_mask   = pwdata;
        REG_LISTEN_PORT: cfg_nxt.listen_port = pwdata[15:0];
        REG_SERIAL_MODE: cfg_nxt.serial_mode = pwdata[0];
        default:         cfg_nxt = cfg_r;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_LAN_ADDR:    prdata = cfg_r.lan_addr;
      REG_WLAN_ADDR:   prdata = cfg_r.wlan_addr;
      REG_LOOP_ADDR:   prdata = cfg_r.loop_addr;
      REG_LAN_MASK:    prdata = cfg_r.lan_mask;
      REG_WLAN_MASK:   prdata = cfg_r.wlan_mask;
      REG_LISTEN_PORT: prdata = {16'd0, cfg_r.listen_port};
      REG_SERIAL_MODE: prdata = {31'd0, cfg_r.serial_mode};
      default:         prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.lan_addr    <= '0;
      cfg_r.wlan_addr   <= '0;
      cfg_r.loop_addr   <= LOOP_ADDR_RST;
      cfg_r.lan_mask    <= '0;
      cfg_r.wlan_mask   <= '0;
      cfg_r.listen_port <= LISTEN_PORT_RST;
      cfg_r.serial_mode <= 1'b0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

// ===== design/lan_ipv4_ingress_filter.sv =====
// lan_ipv4_ingress_filter: top level, three-stage header classification pipeline
// depends on lif_pkg and lif_regs
//
// Judges one parsed ipv4 header per word and returns one result word (accept,
// path) for each, in order. The pipeline has three register stages: address,
// mask and port compares; rule combination into path and verdict; output
// register. A word can be taken every cycle while the output is not stalled,
// so sustained rate is one word per clock; each word passes the stage registers
// in order before out_valid. Each stage advances when the stage after it is
// empty or moving, so a stall at the output fills the empty stages before
// in_ready falls; nothing is dropped or repeated. Configuration is an apb-style
// port, registers at byte offsets 4*i; write it only while no word is in flight.
module lan_ipv4_ingress_filter (
  input  logic                        clk,
  input  logic                        rst_n,
  // input word channel
  input  logic                        in_valid,
  output logic                        in_ready,
  input  lif_pkg::in_word_t           in_data,
  // result word channel
  output logic                        out_valid,
  input  logic                        out_ready,
  output lif_pkg::out_word_t          out_data,
  // configuration port
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [lif_pkg::ADDR_W-1:0]  paddr,
  input  logic [lif_pkg::DATA_W-1:0]  pwdata,
  output logic [lif_pkg::DATA_W-1:0]  prdata,
  output logic                        pready
);
  import lif_pkg::*;

  cfg_t cfg;

  lif_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // stage valids and handshake
  logic v1_r, v1_nxt;
  logic v2_r, v2_nxt;
  logic v3_r, v3_nxt;
  logic adv1, adv2, adv3;

  assign adv3     = !v3_r || out_ready;
  assign adv2     = !v2_r || adv3;
  assign adv1     = !v1_r || adv2;
  assign in_ready = adv1;

  assign v1_nxt = adv1 ? in_valid : v1_r;
  assign v2_nxt = adv2 ? v1_r : v2_r;
  assign v3_nxt = adv3 ? v2_r : v3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v1_r <= v1_nxt;
      v2_r <= v2_nxt;
      v3_r <= v3_nxt;
    end
  end

  // stage 1: all compares against the header and the registers
  flags_t      fl_nxt;
  flags_t      fl_r;
  logic [31:0] lan_net;
  logic [31:0] dst_lan_masked;
  logic [31:0] dst_wlan_masked;
  logic [7:0]  serial_m;

  assign lan_net         = cfg.lan_mask & cfg.lan_addr;
  assign dst_lan_masked  = cfg.lan_mask & in_data.dst_addr;
  assign dst_wlan_masked = cfg.wlan_mask & in_data.dst_addr;
  assign serial_m        = dst_lan_masked[7:0];

  always_comb begin
    fl_nxt.ver_ok      = (in_data.ip_version == IP_VER4);
    fl_nxt.serial      = cfg.serial_mode;
    fl_nxt.src_in_lan  = ((cfg.lan_mask & in_data.src_addr) == lan_net);
    fl_nxt.src_last_ok = (in_data.src_addr[31:24] >= OCT_MIN_HOST);
    fl_nxt.src_eq_lan  = (in_data.src_addr == cfg.lan_addr);
    fl_nxt.src_eq_wlan = (in_data.src_addr == cfg.wlan_addr);
    fl_nxt.src_eq_loop = (in_data.src_addr == cfg.loop_addr);
    fl_nxt.dst_eq_loop = (in_data.dst_addr == cfg.loop_addr);
    fl_nxt.dst_in_lan  = (dst_lan_masked == lan_net);
    // masked destination below multicast and not the private 192 octet;
    // serial builds look at the first octet under the lan mask only
    if (cfg.serial_mode) begin
      fl_nxt.dst_masked_bad = (serial_m < OCT_MCAST) && (serial_m != OCT_PRIV);
    end else begin
      fl_nxt.dst_masked_bad = (dst_wlan_masked < {24'd0, OCT_MCAST}) &&
                              (dst_wlan_masked != {24'd0, OCT_PRIV});
    end
    fl_nxt.dst_first_priv = (in_data.dst_addr[7:0] == OCT_PRIV);
    fl_nxt.dst_mid_ok     = (in_data.dst_addr[23:8] != MID_BCAST);
    fl_nxt.dst_last_ok    = (in_data.dst_addr[31:24] >= OCT_MIN_HOST);
    fl_nxt.is_icmp        = (in_data.protocol == PROTO_ICMP);
    fl_nxt.is_tcp         = (in_data.protocol == PROTO_TCP);
    fl_nxt.is_udp         = (in_data.protocol == PROTO_UDP);
    fl_nxt.port_blocked   = port_blocked(in_data.dest_port);
    fl_nxt.port_is_listen = (in_data.dest_port == cfg.listen_port);
  end

  always_ff @(posedge clk) begin
    if (adv1) begin
      fl_r <= fl_nxt;
    end
  end

  // stage 2: rule combination
  out_word_t res_nxt;
  out_word_t res_r;
  logic      host_path;
  logic      host_drop;
  logic      host_acc;
  logic      own_src;
  logic      own_dst_ok;
  logic      own_acc;

  always_comb begin
    host_path = fl_r.src_in_lan && fl_r.src_last_ok;
    // wireless address only counts outside serial builds
    host_drop = fl_r.src_eq_lan || fl_r.src_eq_loop || fl_r.dst_eq_loop ||
                fl_r.dst_in_lan || fl_r.dst_masked_bad ||
                (!fl_r.serial && fl_r.src_eq_wlan);
    host_acc  = !host_drop && (fl_r.is_icmp || (fl_r.is_udp && !fl_r.port_blocked));

    own_src    = fl_r.src_eq_lan || (!fl_r.serial && fl_r.src_eq_wlan);
    own_dst_ok = fl_r.dst_first_priv && fl_r.dst_mid_ok && fl_r.dst_last_ok &&
                 !fl_r.dst_in_lan;
    own_acc    = own_dst_ok && ((fl_r.is_udp && !fl_r.port_is_listen) ||
                                fl_r.is_tcp || fl_r.is_icmp);

    if (!fl_r.ver_ok) begin
      res_nxt.path   = PATH_NONE;
      res_nxt.accept = 1'b0;
    end else if (host_path) begin
      res_nxt.path   = PATH_HOST;
      res_nxt.accept = host_acc;
    end else if (own_src) begin
      res_nxt.path   = PATH_OWN;
      res_nxt.accept = own_acc;
    end else begin
      res_nxt.path   = PATH_NONE;
      res_nxt.accept = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv2) begin
      res_r <= res_nxt;
    end
  end

  // stage 3: output register
  out_word_t out_r;

  always_ff @(posedge clk) begin
    if (adv3) begin
      out_r <= res_r;
    end
  end

  assign out_valid = v3_r;
  assign out_data  = out_r;

`ifndef NO_ASSERTIONS
  // a dropped input means every stage is full
  a_full_when_blocked: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (v1_r && v2_r && v3_r))
    else $error("in_ready low with an empty stage");

  // an accepted word always lands in stage 1
  a_accept_lands: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> v1_r)
    else $error("accepted word lost at stage 1");

  // a full stage 2 facing a stalled output keeps its word
  a_stage2_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (v2_r && v3_r && !out_ready) |=> (v2_r && $stable(res_r)))
    else $error("stage 2 word changed under stall");

  // accepted packets always name a path, and the code stays in range
  a_accept_has_path: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.accept) |->
      (out_data.path == PATH_HOST || out_data.path == PATH_OWN))
    else $error("accepted packet without a path");

  a_path_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.path != 2'd3))
    else $error("path code out of range");
`endif

endmodule

// ===== tb/sv/lan_ipv4_ingress_filter_test.sv =====
// lan_ipv4_ingress_filter_test: self-checking bench for the ipv4 ingress filter
// depends on lif_pkg and lan_ipv4_ingress_filter; predicts each verdict in place
`timescale 1ns / 100ps

module lan_ipv4_ingress_filter_test;
  import lif_pkg::*;

  // address words keep the first dotted octet in bits 7:0
  localparam logic [31:0] HOME_LAN_ADDR = 32'h0101_a8c0;  // 192.168.1.1
  localparam logic [31:0] HOME_LAN_MASK = 32'h00ff_ffff;  // /24
  localparam logic [31:0] HOME_WL_ADDR  = 32'h0100_000a;  // 10.0.0.1
  localparam logic [31:0] HOME_WL_MASK  = 32'h0000_00ff;  // /8
  localparam logic [31:0] SUBNET_PEER   = 32'h3201_a8c0;  // 192.168.1.50
  localparam logic [31:0] REMOTE_PRIV   = 32'h0705_a8c0;  // 192.168.5.7

  // register settings used by the phases
  localparam int unsigned SET_RESET       = 0;
  localparam int unsigned SET_HOME        = 1;
  localparam int unsigned SET_HOME_SERIAL = 2;
  localparam int unsigned SET_ONES        = 3;
  localparam int unsigned SET_ZEROS       = 4;
  localparam int unsigned SET_RANDOM      = 5;

  localparam int unsigned RANDOM_PHASES   = 9;
  localparam int unsigned WORDS_PER_PHASE = 195;
  localparam int unsigned HOLD_CYCLES     = 300;
  localparam int unsigned CYCLE_LIMIT     = 400000;

  typedef struct {
    int unsigned setting;
    in_word_t    word;
    bit          typed;
    out_word_t   verdict;
  } probe_t;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  in_word_t  in_data;
  logic      out_valid;
  logic      out_ready;
  out_word_t out_data;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [ADDR_W-1:0]   paddr;
  logic [DATA_W-1:0]   pwdata;
  logic [DATA_W-1:0]   prdata;
  logic                pready;

  cfg_t        filter_cfg;        // settings the predictor judges against
  out_word_t   pending_verdicts[$];
  probe_t      probe_rows[$];
  int unsigned mismatches;
  int unsigned cycles;
  bit          calm;              // no idling on either side while set
  bit          hold_req;          // asks the receiver for one long hold-off
  int unsigned hold_left;
  out_word_t   due;

  lan_ipv4_ingress_filter dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // udp ports the subnet host path never lets through
  function automatic logic [15:0] denied_port(int unsigned k);
    case (k)
      0:       return 16'd53;
      1:       return 16'd80;
      2:       return 16'd137;
      3:       return 16'd138;
      4:       return 16'd433;
      5:       return 16'd445;
      6:       return 16'd5353;
      7:       return 16'd5355;
      8:       return 16'd8000;
      9:       return 16'd8080;
      10:      return 16'd11711;
      11:      return 16'd3478;
      default: return 16'd15712;
    endcase
  endfunction

  function automatic bit udp_port_denied(logic [15:0] port);
    bit hit;
    hit = 1'b0;
    for (int k = 0; k < 13; k++)
      if (port == denied_port(k)) hit = 1'b1;
    return hit;
  endfunction

  // verdict of one header under the given settings
  function automatic out_word_t judge_header(cfg_t c, in_word_t w);
    out_word_t   r;
    logic [31:0] net;
    logic [31:0] masked;
    bit          drop;
    bit          own;
    r.accept = 1'b0;
    r.path   = PATH_NONE;
    net = c.lan_mask & c.lan_addr;
    if (w.ip_version != IP_VER4) return r;
    if ((c.lan_mask & w.src_addr) == net && w.src_addr[31:24] >= OCT_MIN_HOST) begin
      r.path = PATH_HOST;
      // serial rules look at the lan-masked first octet only
      masked = c.serial_mode ? (c.lan_mask & w.dst_addr & 32'h0000_00ff)
                             : (c.wlan_mask & w.dst_addr);
      drop = (w.src_addr == c.lan_addr) || (w.src_addr == c.loop_addr) ||
             (!c.serial_mode && w.src_addr == c.wlan_addr) ||
             (w.dst_addr == c.loop_addr) || ((c.lan_mask & w.dst_addr) == net) ||
             (masked < 32'(OCT_MCAST) && masked != 32'(OCT_PRIV));
      if (!drop) begin
        if (w.protocol == PROTO_ICMP) r.accept = 1'b1;
        else if (w.protocol == PROTO_UDP) r.accept = !udp_port_denied(w.dest_port);
      end
      return r;
    end
    own = (w.src_addr == c.lan_addr) || (!c.serial_mode && w.src_addr == c.wlan_addr);
    if (own) begin
      r.path = PATH_OWN;
      if (w.dst_addr[7:0] == OCT_PRIV && w.dst_addr[23:8] != MID_BCAST &&
          w.dst_addr[31:24] >= OCT_MIN_HOST && (c.lan_mask & w.dst_addr) != net) begin
        if (w.protocol == PROTO_UDP) r.accept = (w.dest_port != c.listen_port);
        else if (w.protocol == PROTO_TCP || w.protocol == PROTO_ICMP) r.accept = 1'b1;
      end
    end
    return r;
  endfunction

  function automatic logic [31:0] reg_value(cfg_t c, reg_idx_t idx);
    case (idx)
      REG_LAN_ADDR:    return c.lan_addr;
      REG_WLAN_ADDR:   return c.wlan_addr;
      REG_LOOP_ADDR:   return c.loop_addr;
      REG_LAN_MASK:    return c.lan_mask;
      REG_WLAN_MASK:   return c.wlan_mask;
      REG_LISTEN_PORT: return {16'd0, c.listen_port};
      REG_SERIAL_MODE: return {31'd0, c.serial_mode};
      default:         return 32'd0;
    endcase
  endfunction

  function automatic logic [31:0] rand_mask();
    case ($urandom_range(4))
      0:       return 32'h0000_00ff;
      1:       return 32'h0000_ffff;
      2:       return 32'h00ff_ffff;
      3:       return 32'hffff_ffff;
      default: return $urandom;
    endcase
  endfunction

  function automatic cfg_t pick_cfg(int unsigned setting);
    cfg_t c;
    c.lan_addr    = HOME_LAN_ADDR;
    c.wlan_addr   = HOME_WL_ADDR;
    c.loop_addr   = LOOP_ADDR_RST;
    c.lan_mask    = HOME_LAN_MASK;
    c.wlan_mask   = HOME_WL_MASK;
    c.listen_port = LISTEN_PORT_RST;
    c.serial_mode = 1'b0;
    case (setting)
      SET_RESET: begin
        c.lan_addr  = '0;
        c.wlan_addr = '0;
        c.lan_mask  = '0;
        c.wlan_mask = '0;
      end
      SET_HOME_SERIAL: c.serial_mode = 1'b1;
      SET_ONES:        c = '1;
      SET_ZEROS:       c = '0;
      SET_RANDOM: begin
        c.lan_mask = rand_mask();
        c.lan_addr = $urandom;
        if ($urandom_range(99) < 60) c.lan_addr[7:0] = OCT_PRIV;
        // a wireless address inside the lan subnet reaches the own-source drop
        c.wlan_addr = $urandom;
        if ($urandom_range(1))
          c.wlan_addr = (c.lan_mask & c.lan_addr) | (~c.lan_mask & c.wlan_addr);
        c.wlan_mask = rand_mask();
        if ($urandom_range(99) < 30) c.loop_addr = $urandom;
        case ($urandom_range(3))
          0, 1:    c.listen_port = 16'($urandom);
          2:       c.listen_port = LISTEN_PORT_RST;
          default: c.listen_port = denied_port($urandom_range(12));
        endcase
        c.serial_mode = 1'($urandom_range(1));
      end
      default: ;
    endcase
    return c;
  endfunction

  function automatic logic [31:0] pick_dst(cfg_t c);
    logic [31:0] d;
    int unsigned roll;
    d    = $urandom;
    roll = $urandom_range(99);
    if (roll < 35) begin
      // private 192.x target; sometimes broadcast middle or low last octet
      d[7:0] = OCT_PRIV;
      if ($urandom_range(9) == 0) d[23:8] = MID_BCAST;
      if ($urandom_range(7) == 0) d[31:24] = 8'($urandom_range(4));
    end else if (roll < 50) begin
      d[7:0] = 8'($urandom_range(255, 224));
    end else if (roll < 62) begin
      d = (c.lan_mask & c.lan_addr) | (~c.lan_mask & d);
    end else if (roll < 67) begin
      d = c.loop_addr;
    end
    return d;
  endfunction

  // mostly well-formed headers aimed at both paths, the rest pure noise
  function automatic in_word_t make_header(cfg_t c);
    in_word_t    w;
    int unsigned roll;
    w.ip_version = ($urandom_range(99) < 90) ? IP_VER4 : 4'($urandom);
    w.dest_port  = 16'($urandom);
    w.dst_addr   = pick_dst(c);
    roll = $urandom_range(99);
    if (roll < 15) begin
      w.ip_version = 4'($urandom);
      w.protocol   = 8'($urandom);
      w.src_addr   = $urandom;
      w.dst_addr   = $urandom;
      w.dest_port  = 16'($urandom);
      return w;
    end else if (roll < 55) begin
      w.src_addr = (c.lan_mask & c.lan_addr) | (~c.lan_mask & $urandom);
      case ($urandom_range(9))
        0:       w.src_addr[31:24] = 8'($urandom_range(4));
        1:       w.src_addr = c.lan_addr;
        2:       w.src_addr = c.wlan_addr;
        3:       w.src_addr = c.loop_addr;
        default: w.src_addr[31:24] = 8'($urandom_range(255, 3));
      endcase
    end else if (roll < 85) begin
      w.src_addr = $urandom_range(1) ? c.lan_addr : c.wlan_addr;
    end else begin
      w.src_addr = $urandom;
    end
    roll = $urandom_range(99);
    if (roll < 30) begin
      w.protocol = PROTO_UDP;
      roll = $urandom_range(99);
      if (roll < 30) w.dest_port = denied_port($urandom_range(12));
      else if (roll < 45) w.dest_port = c.listen_port;
    end else if (roll < 55) begin
      w.protocol = PROTO_ICMP;
    end else if (roll < 75) begin
      w.protocol = PROTO_TCP;
    end else begin
      w.protocol = 8'($urandom);
    end
    return w;
  endfunction

  task automatic flag_error(string msg);
    mismatches++;
    if (mismatches <= 10) $display("%s", msg);
  endtask

  task automatic probe(int unsigned setting, logic [3:0] ver, logic [7:0] proto,
                       logic [31:0] src, logic [31:0] dst, logic [15:0] port,
                       bit typed = 1'b0, logic acc = 1'b0, logic [1:0] path = PATH_NONE);
    probe_t p;
    p.setting             = setting;
    p.word.ip_version     = ver;
    p.word.protocol       = proto;
    p.word.src_addr       = src;
    p.word.dst_addr       = dst;
    p.word.dest_port      = port;
    p.typed               = typed;
    p.verdict.accept      = acc;
    p.verdict.path        = path;
    probe_rows.push_back(p);
  endtask

  // apb setup cycle then access cycle; starts and ends on a falling edge
  task automatic reg_write(reg_idx_t idx, logic [31:0] value);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = {idx, 2'b00};
    pwdata  = value;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  task automatic reg_read(reg_idx_t idx, output logic [31:0] value);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b0;
    paddr   = {idx, 2'b00};
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    value = prdata;
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
  endtask

  // write every register, with junk above the narrow ones, then read all back
  task automatic apply_cfg(cfg_t c);
    reg_idx_t    idx;
    logic [31:0] v;
    filter_cfg = c;
    for (int k = 0; k <= int'(REG_SERIAL_MODE); k++) begin
      idx = reg_idx_t'(k);
      v   = reg_value(c, idx);
      if (idx == REG_LISTEN_PORT) v[31:16] = 16'($urandom);
      if (idx == REG_SERIAL_MODE) v[31:1] = 31'($urandom);
      reg_write(idx, v);
    end
    for (int k = 0; k <= int'(REG_SERIAL_MODE); k++) begin
      idx = reg_idx_t'(k);
      reg_read(idx, v);
      if (v !== reg_value(c, idx))
        flag_error($sformatf("register %s reads %h, written %h",
                             idx.name(), v, reg_value(c, idx)));
    end
  endtask

  // offer one header word and log its verdict once it is taken
  task automatic send_word(in_word_t w, bit typed, out_word_t verdict);
    while (!calm && $urandom_range(99) < 34) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_data  = w;
    do @(posedge clk); while (!in_ready);
    pending_verdicts.push_back(typed ? verdict : judge_header(filter_cfg, w));
    @(negedge clk);
  endtask

  // let the pipeline empty before the registers change
  task automatic drain();
    in_valid = 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    @(negedge clk);
  endtask

  // result side: random back-pressure, one long hold-off on request
  initial begin
    out_ready = 1'b0;
    hold_left = 0;
    forever begin
      @(negedge clk);
      if (hold_left != 0) begin
        out_ready = 1'b0;
        hold_left--;
      end else if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_CYCLES;
        out_ready = 1'b0;
      end else begin
        out_ready = calm || ($urandom_range(99) >= 34);
      end
    end
  end

  // compare each taken result word with the oldest verdict due
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (pending_verdicts.size() == 0) begin
        flag_error($sformatf("result word with nothing due: accept %b path %0d",
                             out_data.accept, out_data.path));
      end else begin
        due = pending_verdicts.pop_front();
        if (out_data.accept !== due.accept || out_data.path !== due.path)
          flag_error($sformatf("verdict mismatch: accept %b want %b, path %0d want %0d",
                               out_data.accept, due.accept, out_data.path, due.path));
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles == CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    int unsigned current;
    int unsigned setting;
    rst_n      = 1'b0;
    in_valid   = 1'b0;
    in_data    = '0;
    psel       = 1'b0;
    penable    = 1'b0;
    pwrite     = 1'b0;
    paddr      = '0;
    pwdata     = '0;
    calm       = 1'b0;
    hold_req   = 1'b0;
    mismatches = 0;
    cycles     = 0;
    filter_cfg = pick_cfg(SET_RESET);

    // reset settings: zero lan mask puts every source in the subnet
    probe(SET_RESET, 4'd0, 8'd0, 32'd0, 32'd0, 16'd0, 1'b1, 1'b0, PATH_NONE);
    probe(SET_RESET, 4'hf, 8'hff, '1, '1, 16'hffff, 1'b1, 1'b0, PATH_NONE);
    probe(SET_RESET, IP_VER4, PROTO_ICMP, '1, '1, 16'hffff, 1'b1, 1'b0, PATH_HOST);
    probe(SET_RESET, IP_VER4, PROTO_UDP, 32'd0, 32'd0, 16'd0, 1'b1, 1'b0, PATH_OWN);
    // last octet 2 is one short of a host
    probe(SET_RESET, IP_VER4, PROTO_ICMP, 32'h0200_0001, REMOTE_PRIV, 16'd0,
          1'b1, 1'b0, PATH_NONE);
    // home lan, subnet host path
    probe(SET_HOME, IP_VER4, PROTO_ICMP, SUBNET_PEER, REMOTE_PRIV, 16'd0,
          1'b1, 1'b1, PATH_HOST);
    probe(SET_HOME, IP_VER4, PROTO_UDP, SUBNET_PEER, REMOTE_PRIV, 16'd53);
    probe(SET_HOME, IP_VER4, PROTO_UDP, SUBNET_PEER, REMOTE_PRIV, 16'd0);
    probe(SET_HOME, IP_VER4, PROTO_UDP, SUBNET_PEER, REMOTE_PRIV, 16'hffff);
    probe(SET_HOME, IP_VER4, PROTO_TCP, SUBNET_PEER, REMOTE_PRIV, 16'd80);
    probe(SET_HOME, IP_VER4, 8'hff, SUBNET_PEER, REMOTE_PRIV, 16'd1);
    probe(SET_HOME, IP_VER4, PROTO_UDP, SUBNET_PEER, 32'hfb00_00e0, 16'd5353);
    probe(SET_HOME, IP_VER4, PROTO_UDP, SUBNET_PEER, 32'hfaff_ffef, 16'd1900);
    // masked destination below multicast and not private
    probe(SET_HOME, IP_VER4, PROTO_ICMP, SUBNET_PEER, 32'h0808_0808, 16'd0,
          1'b1, 1'b0, PATH_HOST);
    // destination inside the lan, then loopback
    probe(SET_HOME, IP_VER4, PROTO_ICMP, SUBNET_PEER, 32'h0901_a8c0, 16'd0,
          1'b1, 1'b0, PATH_HOST);
    probe(SET_HOME, IP_VER4, PROTO_ICMP, SUBNET_PEER, LOOP_ADDR_RST, 16'd0,
          1'b1, 1'b0, PATH_HOST);
    // own source path: forward, listen port, broadcast middle, low last octet
    probe(SET_HOME, IP_VER4, PROTO_TCP, HOME_LAN_ADDR, REMOTE_PRIV, 16'd443,
          1'b1, 1'b1, PATH_OWN);
    probe(SET_HOME, IP_VER4, PROTO_UDP, HOME_LAN_ADDR, REMOTE_PRIV, LISTEN_PORT_RST);
    probe(SET_HOME, IP_VER4, PROTO_ICMP, HOME_LAN_ADDR, 32'h09ff_ffc0, 16'd0);
    probe(SET_HOME, IP_VER4, PROTO_ICMP, HOME_LAN_ADDR, 32'h0205_a8c0, 16'd0);
    probe(SET_HOME, IP_VER4, PROTO_UDP, HOME_WL_ADDR, REMOTE_PRIV, 16'd4000);
    // serial rules ignore the wireless address
    probe(SET_HOME_SERIAL, IP_VER4, PROTO_ICMP, HOME_WL_ADDR, REMOTE_PRIV, 16'd0,
          1'b1, 1'b0, PATH_NONE);
    probe(SET_HOME_SERIAL, IP_VER4, PROTO_ICMP, SUBNET_PEER, 32'h0500_000a, 16'd0);
    probe(SET_HOME_SERIAL, IP_VER4, PROTO_ICMP, SUBNET_PEER, REMOTE_PRIV, 16'd0);
    // all-ones settings: the source is the own lan address on the host path
    probe(SET_ONES, IP_VER4, PROTO_ICMP, '1, '1, 16'hffff, 1'b1, 1'b0, PATH_HOST);
    probe(SET_ZEROS, IP_VER4, PROTO_UDP, 32'h0300_0000, 32'd0, 16'd0);

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    current = SET_RANDOM + 1;
    foreach (probe_rows[i]) begin
      if (probe_rows[i].setting != current) begin
        current = probe_rows[i].setting;
        drain();
        apply_cfg(pick_cfg(current));
      end
      send_word(probe_rows[i].word, probe_rows[i].typed, probe_rows[i].verdict);
    end

    // random phases, extremes among them; one phase runs without idling
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      drain();
      setting = (ph == 2) ? SET_ONES : (ph == 5) ? SET_ZEROS : SET_RANDOM;
      apply_cfg(pick_cfg(setting));
      calm = (ph == 3);
      for (int n = 0; n < WORDS_PER_PHASE; n++) begin
        // long receiver hold-off while words keep coming
        if ((ph == 1 && n == 40) || (ph == 6 && n == 100)) hold_req = 1'b1;
        send_word(make_header(filter_cfg), 1'b0, '0);
      end
    end
    calm = 1'b0;

    drain();
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
